@@ rtl/complex_reciprocal_float_defines.svh @@
`ifndef COMPLEX_RECIPROCAL_FLOAT_DEFINES_SVH
`define COMPLEX_RECIPROCAL_FLOAT_DEFINES_SVH

// checked on every clock edge outside reset
`define CRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define CRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/crf_pkg.sv @@
package crf_pkg;

  localparam int DivSteps = 27;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [31:0] SignBit  = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
  } cplx_t;

  // unrounded value m * 2^(e-47), or a finished special word
  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               s;
    logic signed [10:0] e;
    logic [47:0]        m;
  } mul_t;

  typedef struct packed {
    cplx_t              z;
    logic               ok;
    logic               spec;
    logic [31:0]        sval;
    logic signed [10:0] e;
    logic [23:0]        md;
    logic [24:0]        r;
    logic [26:0]        q;
  } div_t;

  function automatic logic [31:0] canon(logic [31:0] b);
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
      return CanonNan;
    end
    return b;
  endfunction

  // normalize, denormalize if needed, round to nearest even, pack
  function automatic logic [31:0] rnd(logic s, logic signed [10:0] e, logic [47:0] m);
    logic [5:0]         lz;
    logic               found;
    logic [47:0]        mn;
    logic [47:0]        mask;
    logic signed [10:0] be;
    logic signed [10:0] sh;
    logic               st;
    logic               g;
    logic               rup;
    logic [24:0]        sm;
    logic [9:0]         fe;
    logic [22:0]        fr;
    if (m == 48'd0) begin
      return {s, 31'd0};
    end
    lz = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && m[i]) begin
        lz = 6'(47 - i);
        found = 1'b1;
      end
    end
    mn = m << lz;
    be = e - $signed({5'd0, lz}) + 11'sd127;
    if (be <= 11'sd0) begin
      sh = 11'sd1 - be;
      if (sh >= 11'sd48) begin
        st = |mn;
        mn = 48'd0;
      end else begin
        mask = (48'd1 << sh[5:0]) - 48'd1;
        st = |(mn & mask);
        mn = mn >> sh[5:0];
      end
      mn[0] = mn[0] | st;
      be = 11'sd0;
    end
    g   = mn[23];
    st  = |mn[22:0];
    rup = g & (st | mn[24]);
    sm  = {1'b0, mn[47:24]} + 25'(rup);
    if (be == 11'sd0) begin
      fe = sm[23] ? 10'd1 : 10'd0;
      fr = sm[22:0];
    end else if (sm[24]) begin
      fe = be[9:0] + 10'd1;
      fr = sm[23:1];
    end else begin
      fe = be[9:0];
      fr = sm[22:0];
    end
    if (fe >= 10'd255) begin
      return {s, 8'hFF, 23'd0};
    end
    return {s, fe[7:0], fr};
  endfunction

  function automatic logic [31:0] rnd_m(mul_t p);
    if (p.spec) begin
      return p.sval;
    end
    return rnd(p.s, p.e, p.m);
  endfunction

  function automatic mul_t fmul_pre(logic [31:0] a, logic [31:0] b);
    mul_t               p;
    logic               za;
    logic               zb;
    logic               ia;
    logic               ib;
    logic               na;
    logic               nb;
    logic signed [10:0] ea;
    logic signed [10:0] eb;
    za = a[30:0] == 31'd0;
    zb = b[30:0] == 31'd0;
    ia = a[30:23] == 8'hFF && a[22:0] == 23'd0;
    ib = b[30:23] == 8'hFF && b[22:0] == 23'd0;
    na = a[30:23] == 8'hFF && a[22:0] != 23'd0;
    nb = b[30:23] == 8'hFF && b[22:0] != 23'd0;
    ea = (a[30:23] == 8'd0) ? -11'sd126 : $signed({3'd0, a[30:23]}) - 11'sd127;
    eb = (b[30:23] == 8'd0) ? -11'sd126 : $signed({3'd0, b[30:23]}) - 11'sd127;
    p.s    = a[31] ^ b[31];
    p.e    = ea + eb + 11'sd1;
    p.m    = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
    p.spec = 1'b0;
    p.sval = CanonNan;
    if (na || nb || (ia && zb) || (ib && za)) begin
      p.spec = 1'b1;
    end else if (ia || ib) begin
      p.spec = 1'b1;
      p.sval = {p.s, 8'hFF, 23'd0};
    end
    return p;
  endfunction

  // sum of two non-negative words (squares)
  function automatic mul_t fadd_pre(logic [31:0] a, logic [31:0] b);
    mul_t               p;
    logic [31:0]        x;
    logic [31:0]        y;
    logic signed [10:0] ex;
    logic signed [10:0] ey;
    logic signed [10:0] d;
    logic [26:0]        my;
    logic [26:0]        mask;
    logic               st;
    logic [27:0]        sum;
    if (a[30:23] >= b[30:23]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex = (x[30:23] == 8'd0) ? -11'sd126 : $signed({3'd0, x[30:23]}) - 11'sd127;
    ey = (y[30:23] == 8'd0) ? -11'sd126 : $signed({3'd0, y[30:23]}) - 11'sd127;
    d  = ex - ey;
    my = {y[30:23] != 8'd0, y[22:0], 3'd0};
    if (d >= 11'sd27) begin
      st = |my;
      my = 27'd0;
    end else begin
      mask = (27'd1 << d[4:0]) - 27'd1;
      st = |(my & mask);
      my = my >> d[4:0];
    end
    my[0] = my[0] | st;
    sum = {1'b0, x[30:23] != 8'd0, x[22:0], 3'd0} + {1'b0, my};
    p.s    = 1'b0;
    p.e    = ex + 11'sd1;
    p.m    = {sum, 20'd0};
    p.spec = 1'b0;
    p.sval = CanonNan;
    if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0)) begin
      p.spec = 1'b1;
    end else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      p.spec = 1'b1;
      p.sval = {1'b0, 8'hFF, 23'd0};
    end
    return p;
  endfunction

  // unpack the divisor for the restoring reciprocal
  function automatic div_t div_init(cplx_t z, logic [31:0] den);
    div_t       t;
    logic [4:0] lz;
    logic       found;
    logic [23:0] mm;
    t.z    = z;
    t.ok   = den != 32'd0;
    t.spec = 1'b0;
    t.sval = CanonNan;
    t.r    = 25'd1 << 23;
    t.q    = 27'd0;
    lz     = 5'd0;
    found  = 1'b0;
    mm     = {den[30:23] != 8'd0, den[22:0]};
    for (int i = 23; i >= 0; i--) begin
      if (!found && mm[i]) begin
        lz = 5'(23 - i);
        found = 1'b1;
      end
    end
    if (den[30:23] == 8'd0) begin
      t.md = mm << lz;
      t.e  = 11'sd126 + $signed({6'd0, lz});
    end else begin
      t.md = mm;
      t.e  = 11'sd127 - $signed({3'd0, den[30:23]});
    end
    if (den[30:23] == 8'hFF) begin
      t.spec = 1'b1;
      t.sval = (den[22:0] != 23'd0) ? CanonNan : 32'd0;
    end
    return t;
  endfunction

  function automatic div_t div_step(div_t t);
    div_t        n;
    logic [24:0] rr;
    n  = t;
    rr = t.r - {1'b0, t.md};
    if (t.r >= {1'b0, t.md}) begin
      n.q = {t.q[25:0], 1'b1};
      n.r = {rr[23:0], 1'b0};
    end else begin
      n.q = {t.q[25:0], 1'b0};
      n.r = {t.r[23:0], 1'b0};
    end
    return n;
  endfunction

endpackage

@@ rtl/crf_sq_add.sv @@
module crf_sq_add (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  crf_pkg::cplx_t z_i,
  output logic          vld_o,
  output crf_pkg::cplx_t z_o,
  output logic [31:0]   den_o
);

  logic [3:0]      v_q;
  crf_pkg::cplx_t  z1_q, z2_q, z3_q, z4_q;
  crf_pkg::mul_t   pr_q, pi_q, sum_q;
  logic [31:0]     sr_q, si_q, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], vld_i};
    end
  end

  // square, round, add, round
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q  <= z_i;
      pr_q  <= crf_pkg::fmul_pre(z_i.re, z_i.re);
      pi_q  <= crf_pkg::fmul_pre(z_i.im, z_i.im);
      z2_q  <= z1_q;
      sr_q  <= crf_pkg::rnd_m(pr_q);
      si_q  <= crf_pkg::rnd_m(pi_q);
      z3_q  <= z2_q;
      sum_q <= crf_pkg::fadd_pre(sr_q, si_q);
      z4_q  <= z3_q;
      den_q <= crf_pkg::rnd_m(sum_q);
    end
  end

  assign vld_o = v_q[3];
  assign z_o   = z4_q;
  assign den_o = den_q;

endmodule

@@ rtl/crf_recip.sv @@
`include "complex_reciprocal_float_defines.svh"

module crf_recip (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  crf_pkg::cplx_t z_i,
  input  logic [31:0]   den_i,
  output logic          vld_o,
  output crf_pkg::cplx_t z_o,
  output logic [31:0]   inv_o,
  output logic          ok_o
);

  logic [crf_pkg::DivSteps+1:0] v_q;
  crf_pkg::div_t                div_q [crf_pkg::DivSteps+1];
  crf_pkg::cplx_t               zo_q;
  logic [31:0]                  inv_q;
  logic                         ok_q;
  crf_pkg::div_t                last;

  assign last = div_q[crf_pkg::DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[crf_pkg::DivSteps:0], vld_i};
    end
  end

  // one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[0] <= crf_pkg::div_init(z_i, den_i);
      for (int k = 1; k <= crf_pkg::DivSteps; k++) begin
        div_q[k] <= crf_pkg::div_step(div_q[k-1]);
      end
      zo_q  <= last.z;
      ok_q  <= last.ok;
      inv_q <= last.spec ? last.sval
                         : crf_pkg::rnd(1'b0, last.e, {last.q, |last.r, 20'd0});
    end
  end

  assign vld_o = v_q[crf_pkg::DivSteps+1];
  assign z_o   = zo_q;
  assign inv_o = inv_q;
  assign ok_o  = ok_q;

  // quotient of 1.0 by a normalized divisor lies in (0.5, 1]
  `CRF_ASSERT(a_quot_norm,
              v_q[crf_pkg::DivSteps] && last.ok && !last.spec |-> last.q[26] || last.q[25],
              "reciprocal quotient not normalized")
  `CRF_ASSERT(a_rem_bound,
              v_q[crf_pkg::DivSteps] && last.ok && !last.spec |-> last.r[24:1] < last.md,
              "reciprocal remainder out of range")

endmodule

@@ rtl/crf_scale.sv @@
`include "complex_reciprocal_float_defines.svh"

module crf_scale (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  crf_pkg::cplx_t z_i,
  input  logic [31:0]   inv_i,
  input  logic          ok_i,
  output logic          vld_o,
  output logic [31:0]   recip_real_o,
  output logic [31:0]   recip_imag_o,
  output logic          ok_o
);

  logic [1:0]    v_q;
  crf_pkg::mul_t pr_q, pi_q;
  logic          ok1_q, ok2_q;
  logic [31:0]   rr_q, ri_q;
  logic [31:0]   rr_d, ri_d;

  always_comb begin
    rr_d = crf_pkg::canon(crf_pkg::rnd_m(pr_q));
    ri_d = crf_pkg::canon(crf_pkg::rnd_m(pi_q) ^ crf_pkg::SignBit);
    if (!ok1_q) begin
      rr_d = 32'd0;
      ri_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q  <= crf_pkg::fmul_pre(z_i.re, inv_i);
      pi_q  <= crf_pkg::fmul_pre(z_i.im, inv_i);
      ok1_q <= ok_i;
      rr_q  <= rr_d;
      ri_q  <= ri_d;
      ok2_q <= ok1_q;
    end
  end

  assign vld_o        = v_q[1];
  assign recip_real_o = rr_q;
  assign recip_imag_o = ri_q;
  assign ok_o         = ok2_q;

  `CRF_ASSERT(a_zero_when_bad, vld_o && !ok_o |-> rr_q == 32'd0 && ri_q == 32'd0,
              "result not cleared for zero magnitude")
  `CRF_ASSERT(a_nan_canon,
              vld_o && ri_q[30:23] == 8'hFF && ri_q[22:0] != 23'd0 |-> ri_q == crf_pkg::CanonNan,
              "imaginary NaN not canonical")

endmodule

@@ rtl/complex_reciprocal_float.sv @@
// channel | dir | tdata (low bit up)                | tuser
// s_axis  | in  | real_part[31:0], imag_part[63:32] | -
// m_axis  | out | recip_real[31:0], recip_imag[63:32] | ok
//
// one transfer per cycle while the pipeline does not hold: square and sum take 4 stages, the
// restoring reciprocal 29 (one quotient bit per divide step), the final scaling 2.
// the whole pipeline advances together; it holds while the output register is
// full and not taken, and s_axis_tready is low only then.
// reset clears the valid bits alone.
`include "complex_reciprocal_float_defines.svh"

module complex_reciprocal_float (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // real_part, imag_part
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // recip_real, recip_imag
  output logic        m_axis_tuser    // ok
);

  logic           en;
  crf_pkg::cplx_t z_in, z_a, z_b;
  logic           v_a, v_b;
  logic [31:0]    den, inv;
  logic           ok_b;
  logic [31:0]    rr, ri;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign z_in.re       = s_axis_tdata[31:0];
  assign z_in.im       = s_axis_tdata[63:32];

  crf_sq_add u_sq_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .z_i    (z_in),
    .vld_o  (v_a),
    .z_o    (z_a),
    .den_o  (den)
  );

  crf_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v_a),
    .z_i    (z_a),
    .den_i  (den),
    .vld_o  (v_b),
    .z_o    (z_b),
    .inv_o  (inv),
    .ok_o   (ok_b)
  );

  crf_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (v_b),
    .z_i          (z_b),
    .inv_i        (inv),
    .ok_i         (ok_b),
    .vld_o        (m_axis_tvalid),
    .recip_real_o (rr),
    .recip_imag_o (ri),
    .ok_o         (m_axis_tuser)
  );

  assign m_axis_tdata = {ri, rr};

  `CRF_ASSERT_ALWAYS(a_ready_rule, s_axis_tready === (!m_axis_tvalid || m_axis_tready),
                     "input ready does not follow output slot")
  `CRF_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> $stable(v_b),
              "pipeline moved during a stall")

endmodule
